### hw/rtl/mqtt_inbound_frame_parser_core_macros.svh
// ---------------------------------------------------------------------------
// mqtt inbound frame parser assertion macros
// shared concurrent check forms for the parser rtl
// ---------------------------------------------------------------------------
`ifndef MQTT_INBOUND_FRAME_PARSER_CORE_MACROS_SVH
`define MQTT_INBOUND_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication, gated off during reset
`define MIFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mifp: same-cycle check failed");

// next-cycle implication, gated off during reset
`define MIFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mifp: next-cycle check failed");

`endif

### hw/rtl/mifp_pkg.sv
// ---------------------------------------------------------------------------
// mifp_pkg
// shared codes, widths and types of the mqtt inbound frame parser
// ---------------------------------------------------------------------------
package mifp_pkg;

    // byte class codes
    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_TOPIC   = 2'd1;
    localparam logic [1:0] CLS_PAYLOAD = 2'd2;
    localparam logic [1:0] CLS_SKIP    = 2'd3;

    // status codes
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_DROP    = 3'd2;
    localparam logic [2:0] ST_LEN_ERR = 3'd3;
    localparam logic [2:0] ST_OTHER   = 3'd4;

    // beat kind on the input side
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // publish type nibble, the only type whose body is split
    localparam logic [3:0] PKT_PUBLISH = 4'h3;

    // keepalive timing
    localparam int unsigned KA_SEC_W   = 16;
    localparam int unsigned ELAPSED_W  = 25;
    localparam int unsigned HALF_MS_W  = 10;
    localparam logic [KA_SEC_W-1:0]  KA_SEC_RESET = 16'd60;
    localparam logic [HALF_MS_W-1:0] KA_HALF_MS   = 10'd500;

    // remaining length and topic widths
    localparam int unsigned LEN_W  = 28;
    localparam int unsigned TLEN_W = 16;

    // per-beat result of the frame parser
    typedef struct packed {
        logic [1:0] byte_class;
        logic [7:0] data_byte;
        logic       packet_end;
        logic [2:0] status;
    } t_frame_res;

endpackage

### hw/rtl/mqtt_inbound_frame_parser_core.sv
// ---------------------------------------------------------------------------
// mqtt_inbound_frame_parser_core
// mqtt 3.1.1 fixed header and publish parser with keepalive ping timer
// ---------------------------------------------------------------------------
// each input beat is either a byte from the broker (tuser 0) or a one ms tick
// (tuser 1) and yields exactly one output beat; bytes walk the fixed header,
// the remaining length varint and the body, splitting publish bodies into
// topic and payload bytes, while ticks advance the keepalive timer; the block
// takes one beat per clock whenever the sink keeps m_axis_tready high; each
// beat passes through the input register and then the output register; a
// keepalive write goes to the keepalive_seconds register and from there
// into the registered half-window threshold that ticks are compared with
module mqtt_inbound_frame_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    input  logic [0:0]                    s_axis_tuser,  // [0] mode
    // result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] data_byte, [11:8] packet_type, [13:12] qos_level,
    // [16:14] status, [17] ping_request, [23:18] zero
    output logic [23:0]                   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,  // [1:0] byte_class
    output logic                          m_axis_tlast,  // packet_end
    // keepalive_seconds register
    input  logic                          i_cfg_we,
    input  logic [mifp_pkg::KA_SEC_W-1:0] i_cfg_wdata
);
    import mifp_pkg::*;

    // input stage
    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;

    // output stage
    logic       r_out_valid;
    logic [1:0] r_cls;
    logic [7:0] r_data;
    logic [7:0] r_hdr;
    logic       r_end;
    logic [2:0] r_status;
    logic       r_ping;

    logic       w_advance;   // input stage moves into the output stage
    logic       w_in_take;
    logic       w_step;
    logic       w_tick;
    t_frame_res w_res;
    logic [7:0] w_hdr;
    logic       w_refresh;
    logic       w_ping;

    // output register frees when empty or drained this cycle
    // no beat is taken while reset is held
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || w_advance);
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign w_step = w_advance && (r_in_mode == MODE_BYTE);
    assign w_tick = w_advance && (r_in_mode == MODE_TICK);

    mifp_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (r_in_byte),
        .o_res     (w_res),
        .o_header  (w_hdr),
        .o_refresh (w_refresh)
    );

    // a completed packet counts as link traffic and restarts the window
    mifp_keepalive u_keepalive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick      (w_tick),
        .i_refresh   (w_refresh),
        .o_ping      (w_ping)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_mode <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance) begin
            r_cls    <= w_res.byte_class;
            r_data   <= w_res.data_byte;
            r_hdr    <= w_hdr;
            r_end    <= w_res.packet_end;
            r_status <= w_res.status;
            r_ping   <= w_ping;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_ping, r_status, r_hdr[2:1], r_hdr[7:4], r_data};
    assign m_axis_tuser  = r_cls;
    assign m_axis_tlast  = r_end;

endmodule

### hw/rtl/mifp_frame.sv
// ---------------------------------------------------------------------------
// mifp_frame
// fixed header, remaining length and publish body state machine
// ---------------------------------------------------------------------------
`include "mqtt_inbound_frame_parser_core_macros.svh"

module mifp_frame (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output mifp_pkg::t_frame_res  o_res,
    output logic [7:0]            o_header,
    output logic                  o_refresh
);
    import mifp_pkg::*;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_TLEN_HI = 3'd2;
    localparam logic [2:0] PH_TLEN_LO = 3'd3;
    localparam logic [2:0] PH_TOPIC   = 3'd4;
    localparam logic [2:0] PH_PKTID   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_SKIP    = 3'd7;

    logic [2:0]        r_phase, n_phase;
    logic [7:0]        r_hdr, n_hdr;
    logic [1:0]        r_lbc, n_lbc;
    logic [LEN_W-1:0]  r_bl, n_bl;
    logic [7:0]        r_tlen_hi, n_tlen_hi;
    logic [TLEN_W-1:0] r_tleft, n_tleft;
    logic [1:0]        r_id, n_id;

    logic [LEN_W-1:0]  w_digit;
    logic [LEN_W-1:0]  w_sum;
    logic [LEN_W-1:0]  w_bl_dec;
    logic [TLEN_W-1:0] w_tlen;
    logic [TLEN_W-1:0] w_tl_dec;
    logic [1:0]        w_id_dec;
    logic              w_to_pktid;
    logic [2:0]        w_nxt;
    t_frame_res        w_res;

    // varint digit placed at 7 bits per length byte already seen
    always_comb begin
        case (r_lbc)
            2'd0:    w_digit = {21'b0, i_byte[6:0]};
            2'd1:    w_digit = {14'b0, i_byte[6:0], 7'b0};
            2'd2:    w_digit = {7'b0, i_byte[6:0], 14'b0};
            default: w_digit = {i_byte[6:0], 21'b0};
        endcase
    end

    assign w_sum      = r_bl + w_digit;
    assign w_bl_dec   = r_bl - LEN_W'(1);
    assign w_tlen     = {r_tlen_hi, i_byte};
    assign w_tl_dec   = r_tleft - TLEN_W'(1);
    assign w_id_dec   = r_id - 2'd1;
    assign w_to_pktid = (r_hdr[2:1] != 2'd0) && (w_bl_dec >= LEN_W'(2));

    always_comb begin
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_lbc     = r_lbc;
        n_bl      = r_bl;
        n_tlen_hi = r_tlen_hi;
        n_tleft   = r_tleft;
        n_id      = r_id;
        w_nxt     = r_phase;
        w_res     = '{byte_class: CLS_NONE, data_byte: 8'd0, packet_end: 1'b0,
                      status: ST_NONE};
        if (i_step) begin
            case (r_phase)
                PH_HEADER: begin
                    n_hdr   = i_byte;
                    n_lbc   = 2'd0;
                    n_bl    = '0;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_bl = w_sum;
                    if (i_byte[7]) begin
                        if (r_lbc == 2'd3) begin
                            w_res.status = ST_LEN_ERR;
                            n_phase      = PH_HEADER;
                            n_lbc        = 2'd0;
                            n_bl         = '0;
                        end else begin
                            n_lbc = r_lbc + 2'd1;
                        end
                    end else if (w_sum == '0) begin
                        w_res.packet_end = 1'b1;
                        w_res.status     = (r_hdr[7:4] == PKT_PUBLISH) ? ST_DROP : ST_OTHER;
                        n_phase          = PH_HEADER;
                    end else begin
                        n_phase = (r_hdr[7:4] == PKT_PUBLISH) ? PH_TLEN_HI : PH_SKIP;
                    end
                end
                default: begin
                    n_bl = w_bl_dec;
                    case (r_phase)
                        PH_TLEN_HI: begin
                            n_tlen_hi = i_byte;
                            w_nxt     = PH_TLEN_LO;
                        end
                        PH_TLEN_LO: begin
                            n_tleft = w_tlen;
                            if (w_tlen != '0) begin
                                w_nxt = PH_TOPIC;
                            end else if (w_to_pktid) begin
                                w_nxt = PH_PKTID;
                                n_id  = 2'd2;
                            end else begin
                                w_nxt = PH_PAYLOAD;
                            end
                        end
                        PH_TOPIC: begin
                            w_res.byte_class = CLS_TOPIC;
                            w_res.data_byte  = i_byte;
                            n_tleft          = w_tl_dec;
                            if (w_tl_dec == '0) begin
                                if (w_to_pktid) begin
                                    w_nxt = PH_PKTID;
                                    n_id  = 2'd2;
                                end else begin
                                    w_nxt = PH_PAYLOAD;
                                end
                            end
                        end
                        PH_PKTID: begin
                            n_id = w_id_dec;
                            if (w_id_dec == 2'd0) begin
                                w_nxt = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD: begin
                            w_res.byte_class = CLS_PAYLOAD;
                            w_res.data_byte  = i_byte;
                        end
                        default: begin
                            w_res.byte_class = CLS_SKIP;
                        end
                    endcase
                    if (w_bl_dec == '0) begin
                        w_res.packet_end = 1'b1;
                        if (r_phase == PH_SKIP) begin
                            w_res.status = ST_OTHER;
                        end else if (w_nxt == PH_PKTID || w_nxt == PH_PAYLOAD) begin
                            w_res.status = ST_ACCEPT;
                        end else begin
                            w_res.status = ST_DROP;
                        end
                        w_nxt = PH_HEADER;
                    end
                    n_phase = w_nxt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr     <= 8'd0;
            r_lbc     <= 2'd0;
            r_bl      <= '0;
            r_tlen_hi <= 8'd0;
            r_tleft   <= '0;
            r_id      <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_lbc     <= n_lbc;
            r_bl      <= n_bl;
            r_tlen_hi <= n_tlen_hi;
            r_tleft   <= n_tleft;
            r_id      <= n_id;
        end
    end

    assign o_res     = w_res;
    assign o_header  = n_hdr;
    assign o_refresh = w_res.packet_end;

    `MIFP_ASSERT_NEXT(a_end_to_header, i_clk, i_rst_n, i_step && w_res.packet_end,
        r_phase == PH_HEADER)
    `MIFP_ASSERT_NOW(a_lenerr_no_end, i_clk, i_rst_n, w_res.status == ST_LEN_ERR,
        !w_res.packet_end && r_phase == PH_LENGTH)
    `MIFP_ASSERT_NOW(a_pktid_count, i_clk, i_rst_n, r_phase == PH_PKTID, r_id != 2'd0)

endmodule

### hw/rtl/mifp_keepalive.sv
// ---------------------------------------------------------------------------
// mifp_keepalive
// millisecond counter and half-window ping request
// ---------------------------------------------------------------------------
`include "mqtt_inbound_frame_parser_core_macros.svh"

module mifp_keepalive (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mifp_pkg::KA_SEC_W-1:0] i_cfg_wdata,
    input  logic                          i_tick,
    input  logic                          i_refresh,
    output logic                          o_ping
);
    import mifp_pkg::*;

    localparam int unsigned PROD_W = KA_SEC_W + HALF_MS_W;

    logic [KA_SEC_W-1:0]  r_ks;
    logic [ELAPSED_W-1:0] r_thresh;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [ELAPSED_W-1:0] w_inc;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_ping;

    // half window in ms, computed from r_ks and registered into r_thresh
    assign w_prod = {{HALF_MS_W{1'b0}}, r_ks} * {{KA_SEC_W{1'b0}}, KA_HALF_MS};

    assign w_inc  = (r_elapsed == {ELAPSED_W{1'b1}}) ? r_elapsed
                                                     : r_elapsed + ELAPSED_W'(1);
    assign w_ping = i_tick && (r_ks != '0) && (w_inc >= r_thresh);

    always_comb begin
        n_elapsed = r_elapsed;
        if (i_tick) begin
            n_elapsed = w_ping ? '0 : w_inc;
        end else if (i_refresh) begin
            n_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks      <= KA_SEC_RESET;
            r_thresh  <= '0;
            r_elapsed <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ks <= i_cfg_wdata;
            end
            r_thresh  <= w_prod[ELAPSED_W-1:0];
            r_elapsed <= n_elapsed;
        end
    end

    assign o_ping = w_ping;

    `MIFP_ASSERT_NEXT(a_ping_clears, i_clk, i_rst_n, w_ping, r_elapsed == '0)
    `MIFP_ASSERT_NOW(a_off_no_ping, i_clk, i_rst_n, r_ks == '0, !w_ping)
    `MIFP_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_tick && !i_refresh,
        r_elapsed == $past(r_elapsed))

endmodule

### bench/tb_mqtt_inbound_frame_parser_core.sv
// ---------------------------------------------------------------------------
// tb_mqtt_inbound_frame_parser_core
// self-checking bench for the mqtt inbound frame parser with keepalive timer
// ---------------------------------------------------------------------------
// input beats are bytes from the broker or one ms ticks; every accepted beat
// runs through a local model of the parser, which queues the one result beat
// it should cause, and the output monitor checks each result beat field by
// field against the oldest queued one. a short table of directed beats comes
// first, then random packets (mostly well formed, some noise, bad varints and
// truncated publishes) over several keepalive settings, the extremes included
// ---------------------------------------------------------------------------
module tb_mqtt_inbound_frame_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mifp_pkg::*;

    // cycles without any accepted beat before the run is called hung
    localparam int unsigned STALL_LIMIT = 2000;
    // random beats per keepalive setting
    localparam int unsigned BEATS_PER_SETTING = 60;

    // parser position inside a frame
    typedef enum logic [2:0] {
        WAIT_HDR, GET_LEN, TLEN_HI, TLEN_LO, TOPIC, PKT_ID, PAYLOAD, SKIP_BODY
    } t_parse_phase;

    // one result beat as the parser should produce it
    typedef struct packed {
        logic [1:0] byte_class;
        logic [7:0] data_byte;
        logic [3:0] packet_type;
        logic [1:0] qos_level;
        logic       packet_end;
        logic [2:0] status;
        logic       ping_request;
    } t_parse_result;

    // one row of the directed table
    typedef struct {
        logic          mode;
        logic [7:0]    rx_byte;
        bit            fixed;   // result typed in below rather than predicted
        t_parse_result result;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic [0:0]  s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] data_byte, [11:8] packet_type, [13:12] qos_level,
    // [16:14] status, [17] ping_request, [23:18] zero
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;   // [1:0] byte_class
    logic        m_axis_tlast;   // packet_end
    logic                i_cfg_we;
    logic [KA_SEC_W-1:0] i_cfg_wdata;

    mqtt_inbound_frame_parser_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // parser model state, mirrors the block's registers
    // ------------------------------------------------------------------
    logic [15:0]  ka_seconds   = KA_SEC_RESET;
    t_parse_phase phase        = WAIT_HDR;
    logic [7:0]   hdr          = 8'h00;
    logic [1:0]   len_cnt      = 2'd0;
    logic [27:0]  left         = 28'd0;   // also accumulates the varint
    logic [15:0]  tlen         = 16'd0;
    logic [15:0]  topic_left   = 16'd0;
    logic [1:0]   id_left      = 2'd0;
    logic [24:0]  elapsed      = 25'd0;

    t_parse_result result_q[$];   // results still owed by the block
    t_directed_row table_rows[$]; // directed stimulus
    int unsigned   beats_sent;
    int unsigned   mismatch_count;
    int unsigned   idle_cycles;
    int unsigned   sink_hold_len;  // long receiver hold-off request
    bit            src_idle_on;
    bit            sink_idle_on;

    // after the topic: packet id only when qos is set and two bytes remain
    function automatic t_parse_phase after_topic_phase();
        if (hdr[2:1] != 2'd0 && left >= 28'd2) begin
            id_left = 2'd2;
            return PKT_ID;
        end
        return PAYLOAD;
    endfunction

    // advance the model by one input beat and return the result it causes
    function automatic t_parse_result predict_parse(input logic mode,
                                                    input logic [7:0] b);
        t_parse_result r;
        t_parse_phase  nxt;
        logic [31:0]   half_window;
        r = '0;
        if (mode == MODE_TICK) begin
            // saturating ms counter, ping at half the keepalive window
            if (elapsed != '1)
                elapsed = elapsed + 25'd1;
            half_window = (32'(ka_seconds) * 32'd1000) / 32'd2;
            if (ka_seconds != 16'd0 && 32'(elapsed) >= half_window) begin
                r.ping_request = 1'b1;
                elapsed = '0;
            end
        end else if (phase == WAIT_HDR) begin
            hdr = b;
            len_cnt = 2'd0;
            left = '0;
            phase = GET_LEN;
        end else if (phase == GET_LEN) begin
            left = left + (28'(b[6:0]) << (7 * len_cnt));
            if (b[7]) begin
                // a continuation bit on the fourth length byte is a framing error
                if (len_cnt == 2'd3) begin
                    r.status = ST_LEN_ERR;
                    phase = WAIT_HDR;
                    len_cnt = 2'd0;
                    left = '0;
                end else begin
                    len_cnt = len_cnt + 2'd1;
                end
            end else if (left == '0) begin
                // empty body ends on the last length byte
                r.packet_end = 1'b1;
                r.status = (hdr[7:4] == PKT_PUBLISH) ? ST_DROP : ST_OTHER;
                phase = WAIT_HDR;
                elapsed = '0;
            end else begin
                phase = (hdr[7:4] == PKT_PUBLISH) ? TLEN_HI : SKIP_BODY;
            end
        end else begin
            nxt = phase;
            left = left - 28'd1;
            case (phase)
                TLEN_HI: begin
                    tlen = {b, 8'h00};
                    nxt = TLEN_LO;
                end
                TLEN_LO: begin
                    tlen = tlen | 16'(b);
                    topic_left = tlen;
                    if (tlen != 16'd0)
                        nxt = TOPIC;
                    else
                        nxt = after_topic_phase();
                end
                TOPIC: begin
                    r.byte_class = CLS_TOPIC;
                    r.data_byte = b;
                    topic_left = topic_left - 16'd1;
                    if (topic_left == 16'd0)
                        nxt = after_topic_phase();
                end
                PKT_ID: begin
                    id_left = id_left - 2'd1;
                    if (id_left == 2'd0)
                        nxt = PAYLOAD;
                end
                PAYLOAD: begin
                    r.byte_class = CLS_PAYLOAD;
                    r.data_byte = b;
                end
                default: begin
                    r.byte_class = CLS_SKIP;
                end
            endcase
            if (left == '0) begin
                // publish counts as accepted once the topic is complete
                r.packet_end = 1'b1;
                if (phase == SKIP_BODY)
                    r.status = ST_OTHER;
                else if (nxt == PKT_ID || nxt == PAYLOAD)
                    r.status = ST_ACCEPT;
                else
                    r.status = ST_DROP;
                nxt = WAIT_HDR;
                elapsed = '0;
            end
            phase = nxt;
        end
        r.packet_type = hdr[7:4];
        r.qos_level = hdr[2:1];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // reporting and output checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // result beats are sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("result beat with none owed", m_axis_tdata, '0);
            end else begin
                want = result_q.pop_front();
                if (m_axis_tuser != want.byte_class)
                    report_mismatch("byte_class", m_axis_tuser, want.byte_class);
                if (m_axis_tdata[7:0] != want.data_byte)
                    report_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
                if (m_axis_tdata[11:8] != want.packet_type)
                    report_mismatch("packet_type", m_axis_tdata[11:8],
                                    want.packet_type);
                if (m_axis_tdata[13:12] != want.qos_level)
                    report_mismatch("qos_level", m_axis_tdata[13:12], want.qos_level);
                if (m_axis_tdata[16:14] != want.status)
                    report_mismatch("status", m_axis_tdata[16:14], want.status);
                if (m_axis_tdata[17] != want.ping_request)
                    report_mismatch("ping_request", m_axis_tdata[17],
                                    want.ping_request);
                if (m_axis_tdata[23:18] != 6'd0)
                    report_mismatch("tdata pad", m_axis_tdata[23:18], 6'd0);
                if (m_axis_tlast != want.packet_end)
                    report_mismatch("packet_end", m_axis_tlast, want.packet_end);
            end
        end
    end

    // hang detector: cycles in which neither side moves a beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_len != 0) begin
                m_axis_tready = 1'b0;
                repeat (sink_hold_len - 1) @(negedge i_clk);
                sink_hold_len = 0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                // mostly short stalls, now and then a long one
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
                m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // offer one beat, optionally after a random gap, and wait for acceptance;
    // tvalid stays high on return so back-to-back beats need no bubble
    task automatic send_beat(input logic mode, input logic [7:0] b,
                             input bit fixed = 1'b0,
                             input t_parse_result fixed_result = '0);
        int unsigned   gap;
        t_parse_result predicted;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 9) == 0)
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                              : $urandom_range(1, 3);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tuser = mode;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predicted = predict_parse(mode, b);
        result_q = {result_q, (fixed ? fixed_result : predicted)};
        beats_sent++;
    endtask

    // a broker byte, sometimes preceded by a tick with a junk data byte
    task automatic send_rx(input logic [7:0] b);
        if ($urandom_range(0, 19) == 0)
            send_beat(MODE_TICK, 8'($urandom));
        send_beat(MODE_BYTE, b);
    endtask

    // drop tvalid, then wait for every owed result and the pipeline tail
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // keepalive writes only with the block idle
    task automatic write_keepalive(input logic [15:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        ka_seconds = v;
        // new window passes through r_ks and then the registered threshold r_thresh
        repeat (3) @(negedge i_clk);
    endtask

    // one random frame: mostly well formed, some noise and broken varints
    task automatic send_random_frame();
        int unsigned kind;
        int unsigned topic_n;
        int unsigned min_len_bytes;
        int unsigned len_bytes;
        int unsigned rem;
        logic [3:0]  ptype;
        logic [7:0]  hb;
        logic [7:0]  lb;
        logic [15:0] tl;
        logic [7:0]  body[$];
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // line noise
            repeat ($urandom_range(1, 6)) send_rx(8'($urandom));
        end else if (kind < 14) begin
            // header followed by four continuation bytes
            send_rx(8'($urandom));
            repeat (4) send_rx({1'b1, 7'($urandom)});
        end else begin
            ptype = ($urandom_range(0, 3) != 0) ? PKT_PUBLISH : 4'($urandom);
            hb = {ptype, 4'($urandom)};
            if (ptype == PKT_PUBLISH) begin
                // topic length, mostly matching the topic, rarely wild
                tl = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 6));
                body = {body, tl[15:8]};
                body = {body, tl[7:0]};
                topic_n = (tl <= 16'd6) ? 32'(tl) : $urandom_range(0, 4);
                repeat (topic_n) body = {body, 8'($urandom)};
                if (hb[2:1] != 2'd0) begin
                    body = {body, 8'($urandom)};
                    body = {body, 8'($urandom)};
                end
                if ($urandom_range(0, 24) == 0)
                    repeat ($urandom_range(100, 300)) body = {body, 8'($urandom)};
                else
                    repeat ($urandom_range(0, 10)) body = {body, 8'($urandom)};
                // truncated publish
                if ($urandom_range(0, 6) == 0)
                    while (body.size() > 0 && $urandom_range(0, 2) != 0)
                        void'(body.pop_back());
            end else begin
                repeat ($urandom_range(0, 8)) body = {body, 8'($urandom)};
            end
            rem = body.size();
            min_len_bytes = (rem < 128) ? 1 : 2;
            // sometimes pad the varint out with zero-valued groups
            len_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(min_len_bytes, 4)
                                                    : min_len_bytes;
            send_rx(hb);
            for (int i = 0; i < len_bytes; i++) begin
                lb = 8'((rem >> (7 * i)) & 32'h7F);
                lb[7] = (i < len_bytes - 1);
                send_rx(lb);
            end
            foreach (body[i])
                send_rx(body[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic t_directed_row fixed_row(input logic mode, input logic [7:0] b,
            input logic [1:0] cls, input logic [3:0] ptype, input logic [1:0] qos,
            input logic pend, input logic [2:0] st);
        t_directed_row row;
        row.mode = mode;
        row.rx_byte = b;
        row.fixed = 1'b1;
        row.result = '{byte_class: cls, data_byte: 8'h00, packet_type: ptype,
                       qos_level: qos, packet_end: pend, status: st,
                       ping_request: 1'b0};
        return row;
    endfunction

    function automatic t_directed_row model_row(input logic mode, input logic [7:0] b);
        t_directed_row row;
        row.mode = mode;
        row.rx_byte = b;
        row.fixed = 1'b0;
        row.result = '0;
        return row;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input t_directed_row row);
        table_rows = {table_rows, row};
    endfunction

    initial begin
        logic [15:0]   ka_plan[5];
        int unsigned   start_count;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = MODE_BYTE;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        beats_sent = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        sink_hold_len = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        //                mode       byte    class     type  qos  end   status
        // tick straight after reset
        add_row(fixed_row(MODE_TICK, 8'h00, CLS_NONE, 4'h0, 2'd0, 1'b0, ST_NONE));
        // empty publish is dropped on its only length byte
        add_row(fixed_row(MODE_BYTE, 8'h30, CLS_NONE, 4'h3, 2'd0, 1'b0, ST_NONE));
        add_row(fixed_row(MODE_BYTE, 8'h00, CLS_NONE, 4'h3, 2'd0, 1'b1, ST_DROP));
        // all-ones header, then a varint that never stops
        add_row(fixed_row(MODE_BYTE, 8'hFF, CLS_NONE, 4'hF, 2'd3, 1'b0, ST_NONE));
        add_row(fixed_row(MODE_BYTE, 8'hFF, CLS_NONE, 4'hF, 2'd3, 1'b0, ST_NONE));
        add_row(fixed_row(MODE_BYTE, 8'hFF, CLS_NONE, 4'hF, 2'd3, 1'b0, ST_NONE));
        add_row(fixed_row(MODE_BYTE, 8'hFF, CLS_NONE, 4'hF, 2'd3, 1'b0, ST_NONE));
        add_row(fixed_row(MODE_BYTE, 8'hFF, CLS_NONE, 4'hF, 2'd3, 1'b0, ST_LEN_ERR));
        // empty non-publish packet
        add_row(fixed_row(MODE_BYTE, 8'hC0, CLS_NONE, 4'hC, 2'd0, 1'b0, ST_NONE));
        add_row(fixed_row(MODE_BYTE, 8'h00, CLS_NONE, 4'hC, 2'd0, 1'b1, ST_OTHER));
        // qos 1 publish: topic "ab", packet id, one payload byte, tick inside
        add_row(model_row(MODE_BYTE, 8'h32));
        add_row(model_row(MODE_BYTE, 8'h07));
        add_row(model_row(MODE_BYTE, 8'h00));
        add_row(model_row(MODE_BYTE, 8'h02));
        add_row(model_row(MODE_BYTE, 8'h61));
        add_row(model_row(MODE_TICK, 8'hA5));
        add_row(model_row(MODE_BYTE, 8'h62));
        add_row(model_row(MODE_BYTE, 8'h12));
        add_row(model_row(MODE_BYTE, 8'h34));
        add_row(model_row(MODE_BYTE, 8'h80));
        // publish ending inside the topic length field
        add_row(model_row(MODE_BYTE, 8'h3B));
        add_row(model_row(MODE_BYTE, 8'h01));
        add_row(model_row(MODE_BYTE, 8'h00));
        // skipped one-byte body
        add_row(model_row(MODE_BYTE, 8'h90));
        add_row(model_row(MODE_BYTE, 8'h01));
        add_row(model_row(MODE_BYTE, 8'h5A));

        foreach (table_rows[i])
            send_beat(table_rows[i].mode, table_rows[i].rx_byte, table_rows[i].fixed,
                      table_rows[i].result);

        // random frames under several keepalive windows, extremes first
        ka_plan[0] = 16'hFFFF;
        ka_plan[1] = 16'd0;
        ka_plan[2] = 16'd1;
        ka_plan[3] = 16'd2;
        ka_plan[4] = 16'($urandom_range(3, 65534));
        foreach (ka_plan[p]) begin
            // first setting runs without any idling on either side
            src_idle_on = (p != 0);
            sink_idle_on = (p != 0);
            write_keepalive(ka_plan[p]);
            // long receiver hold-off while the sender keeps offering
            if (p == 1)
                sink_hold_len = 150;
            // a half-second tick run so the shortest window fires a ping
            if (ka_plan[p] == 16'd1)
                repeat (510) send_beat(MODE_TICK, 8'($urandom));
            start_count = beats_sent;
            while (beats_sent - start_count < BEATS_PER_SETTING)
                send_random_frame();
        end

        // huge remaining length: body bytes keep flowing to the end of the run
        send_rx(8'h35);
        send_rx(8'hFF);
        send_rx(8'hFF);
        send_rx(8'hFF);
        send_rx(8'h7F);
        repeat (40) send_rx(8'($urandom));

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mifp_pkg.sv
hw/rtl/mifp_frame.sv
hw/rtl/mifp_keepalive.sv
hw/rtl/mqtt_inbound_frame_parser_core.sv
bench/tb_mqtt_inbound_frame_parser_core.sv
